>>> sv/scp_pkg.sv
// Shared types and constants for the SPIR-V spec constant patcher.
// No dependencies; imported by scp_parser and spirv_spec_constant_patcher.
package scp_pkg;

    // Opcodes and decorations recognized by the parser
    localparam logic [15:0] OP_DECORATE        = 16'd71;
    localparam logic [15:0] OP_SPEC_CONSTANT   = 16'd50;
    localparam logic [31:0] DECORATION_SPEC_ID = 32'd1;

    // Module header length in words
    localparam logic [2:0]  HEADER_WORDS = 3'd5;

    // Entry registers present on the config port
    localparam int NUM_ENTRY_REGS      = 4;
    localparam int DEFAULT_MAX_PATCHES = 4;

    // Config register indexes
    typedef enum logic [2:0] {
        CFG_PATCH_COUNT = 3'd0,
        CFG_ENTRY0      = 3'd1,
        CFG_ENTRY1      = 3'd2,
        CFG_ENTRY2      = 3'd3,
        CFG_ENTRY3      = 3'd4
    } cfg_idx_t;

    // Live configuration seen by the parser
    typedef struct packed {
        logic [2:0]                     count;
        logic [NUM_ENTRY_REGS-1:0][63:0] entry;
    } patch_cfg_t;

    // One result word
    typedef struct packed {
        logic [31:0] word;
        logic        patched;
        logic        last;
    } result_t;

endpackage

>>> sv/spirv_spec_constant_patcher.sv
// Top level: config registers, parser and registered output stage.
// Depends on scp_pkg and scp_parser.
//
//  channel   ports                                   direction
//  -------   -------------------------------------   ---------
//  s_        s_valid s_ready s_word_in s_module_end  request in
//  m_        m_valid m_ready m_word_out
//            m_was_patched m_module_end_out          result out
//  cfg_      cfg_wr_en cfg_index cfg_wdata           write only
//
// One word per cycle unless m_ready stalls; each result appears in the cycle after
// its request is taken, set by the single output register after the parser logic.
// A new request is taken whenever the output register is empty or draining.
// A stall on m_ready holds the result and lowers s_ready until it is taken.
// Reset (aresetn low, synchronous) clears parser state and config registers.
module spirv_spec_constant_patcher #(
    parameter int MAX_PATCHES = scp_pkg::DEFAULT_MAX_PATCHES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word_in,
    input  logic        s_module_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word_out,
    output logic        m_was_patched,
    output logic        m_module_end_out,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import scp_pkg::*;

    patch_cfg_t cfg_reg;
    result_t    parse_result;
    result_t    out_reg;
    logic       m_valid_reg;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PATCH_COUNT: cfg_reg.count    <= cfg_wdata[2:0];
                CFG_ENTRY0:      cfg_reg.entry[0] <= cfg_wdata;
                CFG_ENTRY1:      cfg_reg.entry[1] <= cfg_wdata;
                CFG_ENTRY2:      cfg_reg.entry[2] <= cfg_wdata;
                CFG_ENTRY3:      cfg_reg.entry[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    scp_parser #(
        .MAX_PATCHES (MAX_PATCHES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .word_in    (s_word_in),
        .module_end (s_module_end),
        .cfg        (cfg_reg),
        .result     (parse_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= parse_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_word_out       = out_reg.word;
    assign m_was_patched    = out_reg.patched;
    assign m_module_end_out = out_reg.last;

    // Checks
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled with empty output register");

endmodule

>>> sv/scp_parser.sv
// Instruction-boundary tracker, id binding and word replacement.
// Depends on scp_pkg. State advances only on an accepted request.
module scp_parser #(
    parameter int MAX_PATCHES = scp_pkg::DEFAULT_MAX_PATCHES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [31:0]          word_in,
    input  logic                 module_end,
    input  scp_pkg::patch_cfg_t  cfg,
    output scp_pkg::result_t     result
);
    import scp_pkg::*;

    localparam int NUM_SLOTS = (MAX_PATCHES < NUM_ENTRY_REGS) ? MAX_PATCHES : NUM_ENTRY_REGS;

    logic [2:0]                 header_seen_reg, header_seen_next;
    logic [15:0]                offset_reg, offset_next;
    logic [15:0]                length_reg, length_next;
    logic [15:0]                kind_reg, kind_next;
    logic [31:0]                first_op_reg, first_op_next;
    logic [31:0]                second_op_reg, second_op_next;
    logic [NUM_SLOTS-1:0][31:0] bound_id_reg, bound_id_next;
    logic [NUM_SLOTS-1:0]       bound_reg, bound_next;
    logic [2:0]                 patches_left_reg, patches_left_next;
    logic                       stopped_reg, stopped_next;

    logic [2:0]  in_use;
    logic [16:0] offset_inc;

    // Entries in use: patch count clipped to the slot count
    assign in_use = (cfg.count > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : cfg.count;
    assign offset_inc = {1'b0, offset_reg} + 17'd1;

    // Next state and result for the word at the input
    always_comb begin
        logic found;
        found             = 1'b0;
        header_seen_next  = header_seen_reg;
        offset_next       = offset_reg;
        length_next       = length_reg;
        kind_next         = kind_reg;
        first_op_next     = first_op_reg;
        second_op_next    = second_op_reg;
        bound_id_next     = bound_id_reg;
        bound_next        = bound_reg;
        patches_left_next = patches_left_reg;
        stopped_next      = stopped_reg;
        result.word       = word_in;
        result.patched    = 1'b0;
        result.last       = module_end;

        if (header_seen_reg < HEADER_WORDS) begin
            if (header_seen_reg == 3'd0) begin
                patches_left_next = in_use;
            end
            header_seen_next = header_seen_reg + 3'd1;
        end else if (!stopped_reg) begin
            if (offset_reg == 16'd0) begin
                // First word of an instruction
                if (patches_left_reg == 3'd0 || word_in[31:16] == 16'd0) begin
                    stopped_next = 1'b1;
                end else begin
                    length_next = word_in[31:16];
                    kind_next   = word_in[15:0];
                    offset_next = (word_in[31:16] == 16'd1) ? 16'd0 : 16'd1;
                end
            end else begin
                if (offset_reg == 16'd1) begin
                    first_op_next = word_in;
                end else if (offset_reg == 16'd2) begin
                    second_op_next = word_in;
                end else if (offset_reg == 16'd3 && length_reg >= 16'd4) begin
                    if (kind_reg == OP_DECORATE && second_op_reg == DECORATION_SPEC_ID) begin
                        // Bind first free entry with matching spec id
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (!found && 3'(j) < in_use && !bound_reg[j] &&
                                cfg.entry[j][63:32] == word_in) begin
                                found            = 1'b1;
                                bound_id_next[j] = first_op_reg;
                                bound_next[j]    = 1'b1;
                            end
                        end
                    end else if (kind_reg == OP_SPEC_CONSTANT) begin
                        // Replace value word from first bound match
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (!found && 3'(j) < in_use && bound_reg[j] &&
                                bound_id_reg[j] == second_op_reg) begin
                                found          = 1'b1;
                                result.word    = cfg.entry[j][31:0];
                                result.patched = 1'b1;
                            end
                        end
                        if (found && patches_left_reg != 3'd0) begin
                            patches_left_next = patches_left_reg - 3'd1;
                        end
                    end
                end
                offset_next = (offset_inc >= {1'b0, length_reg}) ? 16'd0 : offset_inc[15:0];
            end
        end

        // End of module clears all parser state and reloads the patch budget
        if (module_end) begin
            header_seen_next  = 3'd0;
            offset_next       = 16'd0;
            length_next       = 16'd0;
            kind_next         = 16'd0;
            first_op_next     = 32'd0;
            second_op_next    = 32'd0;
            bound_id_next     = '0;
            bound_next        = '0;
            patches_left_next = in_use;
            stopped_next      = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_seen_reg  <= 3'd0;
            offset_reg       <= 16'd0;
            length_reg       <= 16'd0;
            kind_reg         <= 16'd0;
            first_op_reg     <= 32'd0;
            second_op_reg    <= 32'd0;
            bound_id_reg     <= '0;
            bound_reg        <= '0;
            patches_left_reg <= 3'd0;
            stopped_reg      <= 1'b0;
        end else if (accept) begin
            header_seen_reg  <= header_seen_next;
            offset_reg       <= offset_next;
            length_reg       <= length_next;
            kind_reg         <= kind_next;
            first_op_reg     <= first_op_next;
            second_op_reg    <= second_op_next;
            bound_id_reg     <= bound_id_next;
            bound_reg        <= bound_next;
            patches_left_reg <= patches_left_next;
            stopped_reg      <= stopped_next;
        end
    end

    // Checks
    a_patch_only_spec_const: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && result.patched) |-> (kind_reg == OP_SPEC_CONSTANT && offset_reg == 16'd3))
        else $error("patch outside OpSpecConstant value word");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && module_end) |=> (header_seen_reg == 3'd0 && bound_reg == '0 && !stopped_reg))
        else $error("module state not cleared after last word");

    a_stop_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (header_seen_reg == HEADER_WORDS))
        else $error("parsing stopped inside header");

    a_patches_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        patches_left_reg <= 3'(NUM_SLOTS))
        else $error("patches_left above slot count");

endmodule

>>> bench/scp_patch_checker.sv
// Scoreboard for spirv_spec_constant_patcher: mirrors the register writes,
// predicts every output word and compares it with the result channel.
// Depends on scp_pkg.
module scp_patch_checker #(
    parameter int MAX_PATCHES = scp_pkg::DEFAULT_MAX_PATCHES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_word_in,
    input  logic        s_module_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_word_out,
    input  logic        m_was_patched,
    input  logic        m_module_end_out,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          pending_words,
    output int          patched_words
);
    import scp_pkg::*;

    localparam int ENTRY_LIMIT = (MAX_PATCHES < NUM_ENTRY_REGS) ? MAX_PATCHES : NUM_ENTRY_REGS;

    // register copies
    logic [2:0]  cfg_count;
    logic [63:0] cfg_entry [NUM_ENTRY_REGS];

    // parser copy
    logic [2:0]  hdr_words;
    logic [15:0] word_pos;
    logic [15:0] instr_len;
    logic [15:0] instr_op;
    logic [31:0] first_opnd;
    logic [31:0] second_opnd;
    logic [31:0] bound_id [ENTRY_LIMIT];
    logic        bound    [ENTRY_LIMIT];
    logic [2:0]  patches_left;
    logic        stopped;

    result_t     expected_words [$];

    function automatic int active_entries();
        return (cfg_count > ENTRY_LIMIT) ? ENTRY_LIMIT : int'(cfg_count);
    endfunction

    task automatic clear_module();
        int j;
        hdr_words    = '0;
        word_pos     = '0;
        instr_len    = '0;
        instr_op     = '0;
        first_opnd   = '0;
        second_opnd  = '0;
        for (j = 0; j < ENTRY_LIMIT; j++) begin
            bound_id[j] = '0;
            bound[j]    = 1'b0;
        end
        patches_left = 3'(active_entries());
        stopped      = 1'b0;
    endtask

    // Predict the output word for one request and advance the parser copy
    task automatic compute_patched_word(input logic [31:0] w, input logic last);
        result_t r;
        int      n;
        int      j;
        int      k;
        bit      hit;
        r.word    = w;
        r.patched = 1'b0;
        r.last    = last;
        n         = active_entries();
        hit       = 1'b0;
        if (hdr_words < HEADER_WORDS) begin
            // header words pass; the first one reloads the patch budget
            if (hdr_words == '0)
                patches_left = 3'(n);
            hdr_words = hdr_words + 3'd1;
        end else if (!stopped) begin
            if (word_pos == '0) begin
                if (patches_left == '0 || w[31:16] == '0) begin
                    stopped = 1'b1;
                end else begin
                    instr_len = w[31:16];
                    instr_op  = w[15:0];
                    word_pos  = (w[31:16] == 16'd1) ? 16'd0 : 16'd1;
                end
            end else begin
                if (word_pos == 16'd1) begin
                    first_opnd = w;
                end else if (word_pos == 16'd2) begin
                    second_opnd = w;
                end else if (word_pos == 16'd3 && instr_len >= 16'd4) begin
                    if (instr_op == OP_DECORATE && second_opnd == DECORATION_SPEC_ID) begin
                        // bind the first free entry whose spec id matches
                        for (j = 0; j < n; j++) begin
                            if (!hit && !bound[j] && cfg_entry[j][63:32] == w) begin
                                bound_id[j] = first_opnd;
                                bound[j]    = 1'b1;
                                hit         = 1'b1;
                            end
                        end
                    end else if (instr_op == OP_SPEC_CONSTANT) begin
                        for (j = 0; j < n; j++) begin
                            if (!hit && bound[j] && bound_id[j] == second_opnd) begin
                                r.word    = cfg_entry[j][31:0];
                                r.patched = 1'b1;
                                if (patches_left != '0)
                                    patches_left = patches_left - 3'd1;
                                hit = 1'b1;
                            end
                        end
                    end
                end
                k = int'(word_pos) + 1;
                word_pos = (k >= int'(instr_len)) ? 16'd0 : 16'(k);
            end
        end
        expected_words.push_back(r);
        if (last)
            clear_module();
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        int      j;
        if (!aresetn) begin
            cfg_count = '0;
            for (j = 0; j < NUM_ENTRY_REGS; j++)
                cfg_entry[j] = '0;
            clear_module();
            expected_words.delete();
            fail_count    = 0;
            patched_words = 0;
        end else begin
            // register writes; indexes past the entry list are dropped
            if (cfg_wr_en) begin
                if (cfg_index == CFG_PATCH_COUNT)
                    cfg_count = cfg_wdata[2:0];
                else if (cfg_index >= CFG_ENTRY0 && cfg_index <= CFG_ENTRY3)
                    cfg_entry[cfg_index - CFG_ENTRY0] = cfg_wdata;
            end
            if (s_valid && s_ready)
                compute_patched_word(s_word_in, s_module_end);
            // compare each result with the oldest prediction
            if (m_valid && m_ready) begin
                if (m_was_patched)
                    patched_words++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %h with nothing pending", m_word_out);
                    fail_count++;
                end else begin
                    exp_r = expected_words.pop_front();
                    if (m_word_out !== exp_r.word) begin
                        $error("word_out: expected %h, got %h", exp_r.word, m_word_out);
                        fail_count++;
                    end
                    if (m_was_patched !== exp_r.patched) begin
                        $error("was_patched: expected %b, got %b", exp_r.patched, m_was_patched);
                        fail_count++;
                    end
                    if (m_module_end_out !== exp_r.last) begin
                        $error("module_end_out: expected %b, got %b",
                               exp_r.last, m_module_end_out);
                        fail_count++;
                    end
                end
            end
        end
        pending_words = expected_words.size();
    end

endmodule

>>> bench/spirv_spec_constant_patcher_tb.sv
// Top-level bench for spirv_spec_constant_patcher: streams SPIR-V modules,
// reprograms the patch table between phases and gives the verdict.
// Depends on scp_pkg, the RTL and scp_patch_checker.
module spirv_spec_constant_patcher_tb;
    import scp_pkg::*;

    localparam int         WORD_TARGET        = 1550;
    localparam int         RUN_LIMIT          = 2_000_000;
    localparam int         MAX_WAIT           = 17;
    localparam logic [2:0] FIRST_UNMAPPED_IDX = 3'(NUM_ENTRY_REGS + 1);
    localparam logic [2:0] LAST_CFG_IDX       = 3'b111;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [31:0] s_word_in        = '0;
    logic        s_module_end     = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [31:0] m_word_out;
    logic        m_was_patched;
    logic        m_module_end_out;
    logic        cfg_wr_en        = 1'b0;
    logic [2:0]  cfg_index        = '0;
    logic [63:0] cfg_wdata        = '0;

    int          fail_count;
    int          pending_words;
    int          patched_words;
    int          words_sent       = 0;
    int          modules_sent     = 0;
    int          settings_used    = 0;
    bit          source_calm      = 1'b0;
    bit          sink_calm        = 1'b0;
    logic [31:0] spec_ids [NUM_ENTRY_REGS];
    logic [31:0] module_words [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    spirv_spec_constant_patcher dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_word_in        (s_word_in),
        .s_module_end     (s_module_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_out       (m_word_out),
        .m_was_patched    (m_was_patched),
        .m_module_end_out (m_module_end_out),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    scp_patch_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_word_in        (s_word_in),
        .s_module_end     (s_module_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_out       (m_word_out),
        .m_was_patched    (m_was_patched),
        .m_module_end_out (m_module_end_out),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending_words    (pending_words),
        .patched_words    (patched_words)
    );

    // All tasks below start and end on a falling edge.

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_words != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // patch count with random junk in the unused upper bits
    task automatic load_count(input logic [2:0] cnt);
        logic [63:0] data;
        data      = {$urandom, $urandom};
        data[2:0] = cnt;
        write_reg(CFG_PATCH_COUNT, data);
    endtask

    // small spec ids so decorations collide often; extremes now and then
    task automatic load_entry(input int j);
        logic [31:0] spec;
        logic [31:0] value;
        case ($urandom_range(0, 7))
            0:       spec = '1;
            1:       spec = $urandom;
            default: spec = $urandom_range(0, 5);
        endcase
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom;
        endcase
        spec_ids[j] = spec;
        write_reg(3'(int'(CFG_ENTRY0) + j), {spec, value});
    endtask

    task automatic push_word(input logic [31:0] w, input logic last);
        int gap;
        gap = source_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_word_in    = w;
        s_module_end = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_result_id();
        return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 6);
    endfunction

    function automatic logic [31:0] pick_spec_id();
        case ($urandom_range(0, 7))
            5, 6:    return $urandom_range(0, 5);
            7:       return $urandom;
            default: return spec_ids[$urandom_range(0, NUM_ENTRY_REGS - 1)];
        endcase
    endfunction

    // New register setting; every few phases force the count extremes
    task automatic program_patches();
        logic [2:0] cnt;
        int         j;
        wait_idle();
        if (settings_used % 6 == 2)
            cnt = '0;
        else if (settings_used % 6 == 4)
            cnt = '1;
        else if ($urandom_range(0, 3) == 0)
            cnt = 3'($urandom_range(0, 7));
        else
            cnt = 3'($urandom_range(1, 4));
        load_count(cnt);
        for (j = 0; j < NUM_ENTRY_REGS; j++)
            load_entry(j);
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(FIRST_UNMAPPED_IDX, LAST_CFG_IDX)),
                      {$urandom, $urandom});
        settings_used++;
    endtask

    // Registers change inside a module: bindings and budget must survive
    task automatic retune_midstream();
        wait_idle();
        if ($urandom_range(0, 1))
            load_count(3'($urandom_range(0, 7)));
        load_entry($urandom_range(0, NUM_ENTRY_REGS - 1));
        settings_used++;
    endtask

    // Mostly well-formed modules: header, then decorations, spec constants
    // and other instructions; some broken counts and cut-short endings.
    task automatic build_module();
        int          n_instr;
        int          pick;
        int          count_field;
        int          n_push;
        int          j;
        logic [15:0] opcode;
        logic [31:0] opnd [1:3];
        module_words.delete();
        if ($urandom_range(0, 19) == 0) begin
            n_push = $urandom_range(1, 6);
            repeat (n_push) module_words.push_back($urandom);
            return;
        end
        repeat (HEADER_WORDS) module_words.push_back($urandom);
        n_instr = $urandom_range(1, 12);
        repeat (n_instr) begin
            pick    = $urandom_range(0, 19);
            opnd[1] = $urandom;
            opnd[2] = $urandom;
            opnd[3] = $urandom;
            if (pick < 7) begin
                opcode      = OP_DECORATE;
                count_field = ($urandom_range(0, 4) == 0) ? 5 : 4;
                opnd[1]     = pick_result_id();
                opnd[2]     = DECORATION_SPEC_ID;
                opnd[3]     = pick_spec_id();
            end else if (pick < 13) begin
                opcode      = OP_SPEC_CONSTANT;
                count_field = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 4;
                opnd[2]     = pick_result_id();
            end else if (pick < 16) begin
                // other decorations, and spec id decorations of odd length
                opcode      = OP_DECORATE;
                count_field = $urandom_range(3, 5);
                opnd[1]     = pick_result_id();
                opnd[2]     = $urandom_range(0, 1) ? DECORATION_SPEC_ID
                                                   : 32'($urandom_range(0, 45));
                opnd[3]     = pick_spec_id();
            end else if (pick < 19) begin
                opcode      = 16'($urandom);
                count_field = $urandom_range(1, 6);
            end else begin
                // zero word count, or a count that runs past the module
                opcode      = 16'($urandom);
                count_field = $urandom_range(0, 1) ? 0 : $urandom_range(7, 16'hFFFF);
            end
            n_push = (count_field > 6) ? 4 : count_field;
            module_words.push_back({16'(count_field), opcode});
            for (j = 1; j < n_push; j++)
                module_words.push_back((j <= 3) ? opnd[j] : $urandom);
        end
        // module ends part way through its last instruction
        if ($urandom_range(0, 7) == 0) begin
            n_push = $urandom_range(1, 3);
            repeat (n_push)
                if (module_words.size() > 1)
                    void'(module_words.pop_back());
        end
    endtask

    task automatic send_module();
        int pause_at;
        int i;
        pause_at = -1;
        if (module_words.size() > 1 && $urandom_range(0, 4) == 0)
            pause_at = $urandom_range(1, module_words.size() - 1);
        for (i = 0; i < module_words.size(); i++) begin
            if (i == pause_at)
                retune_midstream();
            push_word(module_words[i], i == module_words.size() - 1);
        end
        modules_sent++;
    endtask

    // Result side: random stall before each result, none in calm phases
    initial begin : sink
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int n_mod;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed module: two bindings at the id extremes, both patched,
        // then the exhausted budget stops parsing.
        load_count(3'd2);
        write_reg(CFG_ENTRY0, {32'd7, 32'hFFFF_FFFF});
        write_reg(CFG_ENTRY1, {32'hFFFF_FFFF, 32'h0000_0000});
        spec_ids[0] = 32'd7;
        spec_ids[1] = 32'hFFFF_FFFF;
        spec_ids[2] = '0;
        spec_ids[3] = '0;
        settings_used++;
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        repeat (3) push_word($urandom, 1'b0);
        push_word({16'd4, OP_DECORATE}, 1'b0);
        push_word(32'd10, 1'b0);
        push_word(DECORATION_SPEC_ID, 1'b0);
        push_word(32'd7, 1'b0);
        push_word({16'd4, OP_DECORATE}, 1'b0);
        push_word(32'd11, 1'b0);
        push_word(DECORATION_SPEC_ID, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word({16'd4, OP_SPEC_CONSTANT}, 1'b0);
        push_word(32'd1, 1'b0);
        push_word(32'd10, 1'b0);
        push_word(32'h0000_1234, 1'b0);
        push_word({16'd4, OP_SPEC_CONSTANT}, 1'b0);
        push_word(32'd1, 1'b0);
        push_word(32'd11, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word({16'd2, 16'hFFFF}, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);

        // Count above the entry limit, write to an unmapped index,
        // then a zero word count right after the header.
        wait_idle();
        write_reg(CFG_PATCH_COUNT, '1);
        write_reg(LAST_CFG_IDX, '1);
        settings_used++;
        repeat (HEADER_WORDS) push_word($urandom, 1'b0);
        push_word({16'd0, OP_DECORATE}, 1'b0);
        push_word({16'd4, OP_SPEC_CONSTANT}, 1'b1);

        // Random phases: new setting, then a few modules
        while (words_sent < WORD_TARGET) begin
            program_patches();
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            n_mod       = $urandom_range(1, 3);
            repeat (n_mod) begin
                build_module();
                send_module();
            end
        end

        s_valid = 1'b0;
        while (pending_words != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        $display("Sent %0d words in %0d modules over %0d register settings;",
                 words_sent, modules_sent, settings_used);
        $display("%0d result words came back patched.", patched_words);
        if (fail_count == 0 && pending_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule
